// ----- rtl/core/hbkd_pkg.sv -----
// shared types, constants and lookup functions for the boot keyboard decoder
package hbkd_pkg;

  localparam int unsigned KeySlots = 6;

  localparam logic [1:0] CMD_REPORT  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] KIND_HELD = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_NAV  = 2'd2;
  localparam logic [1:0] KIND_LED  = 2'd3;

  localparam logic [7:0] USAGE_PHANTOM = 8'h01;
  localparam logic [7:0] USAGE_CAPS    = 8'h39;
  localparam logic [7:0] USAGE_NUM     = 8'h53;
  localparam logic [7:0] SHIFT_MASK    = 8'h22;
  localparam logic [7:0] FKEY_BASE     = 8'hB0;

  // one job handed from the front to the back
  typedef struct packed {
    logic [1:0]  cmd;
    logic        game;
    logic [7:0]  mods;
    logic [7:0]  prev_mods;
    logic [47:0] us;
    logic [47:0] prev;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [2:0]  cnt;
    logic [3:0]  nav;
    logic        led_send;
    logic [1:0]  led;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key_code;
    logic        pressed;
    logic [63:0] held_low;
    logic [63:0] held_high;
    logic [2:0]  held_count;
    logic [3:0]  nav_dirs;
    logic [1:0]  led_bits;
    logic        last;
  } res_t;

  function automatic logic [7:0] plain_map(input logic [7:0] u);
    logic [7:0] r;
    r = 8'h00;
    if (u >= 8'h04 && u <= 8'h1D) r = 8'h61 + (u - 8'h04);
    else if (u >= 8'h1E && u <= 8'h26) r = 8'h31 + (u - 8'h1E);
    else begin
      case (u)
        8'h27: r = 8'h30; 8'h28: r = 8'h0D; 8'h29: r = 8'h1B; 8'h2A: r = 8'h08;
        8'h2B: r = 8'h09; 8'h2C: r = 8'h20; 8'h2D: r = 8'h2D; 8'h2E: r = 8'h3D;
        8'h2F: r = 8'h5B; 8'h30: r = 8'h5D; 8'h31: r = 8'h5C; 8'h33: r = 8'h3B;
        8'h34: r = 8'h27; 8'h35: r = 8'h60; 8'h36: r = 8'h2C; 8'h37: r = 8'h2E;
        8'h38: r = 8'h2F;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] shift_map(input logic [7:0] u);
    logic [7:0] r;
    r = 8'h00;
    if (u >= 8'h04 && u <= 8'h1D) r = 8'h41 + (u - 8'h04);
    else begin
      case (u)
        8'h1E: r = 8'h21; 8'h1F: r = 8'h40; 8'h20: r = 8'h23; 8'h21: r = 8'h24;
        8'h22: r = 8'h25; 8'h23: r = 8'h5E; 8'h24: r = 8'h26; 8'h25: r = 8'h2A;
        8'h26: r = 8'h28; 8'h27: r = 8'h29; 8'h28: r = 8'h0D; 8'h29: r = 8'h1B;
        8'h2A: r = 8'h08; 8'h2B: r = 8'h09; 8'h2C: r = 8'h20; 8'h2D: r = 8'h5F;
        8'h2E: r = 8'h2B; 8'h2F: r = 8'h7B; 8'h30: r = 8'h7D; 8'h31: r = 8'h7C;
        8'h33: r = 8'h3A; 8'h34: r = 8'h22; 8'h35: r = 8'h7E; 8'h36: r = 8'h3C;
        8'h37: r = 8'h3E; 8'h38: r = 8'h3F;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] game_code(input logic [7:0] u);
    logic [7:0] r;
    r = 8'h00;
    if (u < 8'h39) r = plain_map(u);
    else if (u >= 8'h3A && u <= 8'h43) r = FKEY_BASE + (u - 8'h3A);
    else if (u >= 8'h59 && u <= 8'h61) r = 8'h31 + (u - 8'h59);
    else begin
      case (u)
        8'h39: r = 8'h8E; 8'h44: r = 8'hBA; 8'h45: r = 8'hBB; 8'h46: r = 8'hA0;
        8'h47: r = 8'hA1; 8'h48: r = 8'hA2; 8'h49: r = 8'h8A; 8'h4A: r = 8'h86;
        8'h4B: r = 8'h88; 8'h4C: r = 8'h7F; 8'h4D: r = 8'h87; 8'h4E: r = 8'h89;
        8'h4F: r = 8'h84; 8'h50: r = 8'h83; 8'h51: r = 8'h82; 8'h52: r = 8'h81;
        8'h53: r = 8'h8F; 8'h54: r = 8'h2F; 8'h55: r = 8'h2A; 8'h56: r = 8'h2D;
        8'h57: r = 8'h2B; 8'h58: r = 8'h0D; 8'h62: r = 8'h30; 8'h63: r = 8'h2E;
        8'h65: r = 8'hA3;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] ui_char(input logic [7:0] u, input logic shift,
                                         input logic caps, input logic num);
    logic [7:0] r;
    r = 8'h00;
    if (u >= 8'h04 && u <= 8'h1D) r = (shift ^ caps) ? shift_map(u) : plain_map(u);
    else if (u < 8'h39) r = shift ? shift_map(u) : plain_map(u);
    else if (u == 8'h4A) r = 8'h02;
    else if (u == 8'h4C) r = 8'h7F;
    else if (u == 8'h4D) r = 8'h03;
    else if (u == 8'h58) r = 8'h0D;
    else if (num) begin
      if (u >= 8'h59 && u <= 8'h61) r = 8'h31 + (u - 8'h59);
      else begin
        case (u)
          8'h54: r = 8'h2F; 8'h55: r = 8'h2A; 8'h56: r = 8'h2D;
          8'h57: r = 8'h2B; 8'h62: r = 8'h30; 8'h63: r = 8'h2E;
          default: r = 8'h00;
        endcase
      end
    end else begin
      case (u)
        8'h5F: r = 8'h02; 8'h59: r = 8'h03; 8'h63: r = 8'h7F;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] mod_mask(input logic [1:0] m);
    logic [7:0] r;
    case (m)
      2'd0: r = 8'h22;
      2'd1: r = 8'h11;
      2'd2: r = 8'h44;
      default: r = 8'h88;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] mod_code(input logic [1:0] m);
    logic [7:0] r;
    case (m)
      2'd0: r = 8'h80;
      2'd1: r = 8'h8B;
      2'd2: r = 8'h8C;
      default: r = 8'h8D;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/hid_boot_keyboard_report_decoder.sv -----
// top level of the boot keyboard report decoder
// Requests (reports, release-all, 1 ms ticks) are accepted one per cycle, while
// the job register is free, into a front stage that updates lock, arrow and age
// state and builds the held image; a one-entry job register feeds a back
// sequencer that emits one result per cycle, while the output register is free
// or being popped, up to 17 per request, into an output register. A request is
// taken whenever the job register is free, so throughput is set by the result
// count of the request ahead. cmd 3 and phantom reports give no result.
module hid_boot_keyboard_report_decoder import hbkd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic        game_mode_i,
  input  logic [7:0]  modifiers_i,
  input  logic [7:0]  usage_0_i,
  input  logic [7:0]  usage_1_i,
  input  logic [7:0]  usage_2_i,
  input  logic [7:0]  usage_3_i,
  input  logic [7:0]  usage_4_i,
  input  logic [7:0]  usage_5_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  key_code_o,
  output logic        pressed_o,
  output logic [63:0] held_low_o,
  output logic [63:0] held_high_o,
  output logic [2:0]  held_count_o,
  output logic [3:0]  nav_dirs_o,
  output logic [1:0]  led_bits_o,
  output logic        last_o
);

  localparam logic REG_DELAY = 1'b0;

  logic [15:0] delay_q, interval_q;
  logic        jv, jr, rv;
  job_t        job;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= 16'd400;
      interval_q <= 16'd150;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DELAY) delay_q <= cfg_wdata_i;
      else interval_q <= cfg_wdata_i;
    end
  end

  hbkd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .cmd_i, .game_mode_i, .modifiers_i,
    .usages_i({usage_5_i, usage_4_i, usage_3_i, usage_2_i, usage_1_i, usage_0_i}),
    .delay_i(delay_q), .interval_i(interval_q),
    .job_valid_o(jv), .job_o(job), .job_ready_i(jr)
  );

  hbkd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_i(job), .job_ready_o(jr),
    .res_valid_o(rv), .res_o(res), .res_ready_i(pop)
  );

  assign empty        = !rv;
  assign kind_o       = res.kind;
  assign key_code_o   = res.key_code;
  assign pressed_o    = res.pressed;
  assign held_low_o   = res.held_low;
  assign held_high_o  = res.held_high;
  assign held_count_o = res.held_count;
  assign nav_dirs_o   = res.nav_dirs;
  assign led_bits_o   = res.led_bits;
  assign last_o       = res.last;

endmodule

// ----- rtl/core/hbkd_front.sv -----
// front: accepts requests, updates key and lock state, builds held image
module hbkd_front import hbkd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  cmd_i,
  input  logic        game_mode_i,
  input  logic [7:0]  modifiers_i,
  input  logic [47:0] usages_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] interval_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_ready_i
);

  logic [7:0]  prev_mods_q, prev_mods_d;
  logic [47:0] prev_q, prev_d;
  logic        caps_q, caps_d, num_q, num_d, led_due_q, led_due_d;
  logic [3:0]  arrows_q, arrows_d;
  logic [15:0] press_q, press_d, rep_q, rep_d;
  logic        acc, phantom, shift, caps_t, num_t, in_prev, emit;
  logic [7:0]  u, ch;
  logic [63:0] lo, hi;
  logic [2:0]  cnt;
  logic [3:0]  arr, newly;
  logic [15:0] pa, ra;
  job_t        j;

  assign full_o = !job_ready_i;
  assign acc    = push_i && job_ready_i;

  always_comb begin
    prev_mods_d = prev_mods_q;
    prev_d      = prev_q;
    caps_d      = caps_q;
    num_d       = num_q;
    led_due_d   = led_due_q;
    arrows_d    = arrows_q;
    press_d     = press_q;
    rep_d       = rep_q;
    phantom     = 1'b1;
    shift       = (modifiers_i & SHIFT_MASK) != 8'h00;
    lo = '0; hi = '0; cnt = '0; arr = '0; newly = '0;
    caps_t = caps_q; num_t = num_q;
    u = '0; ch = '0; in_prev = 1'b0;
    pa = press_q; ra = rep_q;
    emit = 1'b0;
    j = '0;
    j.cmd = cmd_i; j.game = game_mode_i; j.mods = modifiers_i;
    j.prev_mods = prev_mods_q; j.us = usages_i; j.prev = prev_q;
    for (int i = 0; i < KeySlots; i++) begin
      if (usages_i[i*8 +: 8] != USAGE_PHANTOM) phantom = 1'b0;
    end
    case (cmd_i)
      CMD_REPORT: begin
        if (!phantom) begin
          emit = 1'b1;
          for (int i = 0; i < KeySlots; i++) begin
            u = usages_i[i*8 +: 8];
            in_prev = 1'b0;
            for (int k = 0; k < KeySlots; k++) begin
              if (prev_q[k*8 +: 8] == u) in_prev = 1'b1;
            end
            if (u == USAGE_CAPS && !in_prev) begin
              caps_t = !caps_t; led_due_d = 1'b1;
            end
            if (u == USAGE_NUM && !in_prev) begin
              num_t = !num_t; led_due_d = 1'b1;
            end
          end
          caps_d = caps_t; num_d = num_t;
          for (int i = 0; i < KeySlots; i++) begin
            ch = ui_char(usages_i[i*8 +: 8], shift, caps_t, num_t) & 8'h7F;
            if (ch != 8'h00) begin
              if (ch[6]) begin
                if (!hi[ch[5:0]]) cnt = cnt + 3'd1;
                hi[ch[5:0]] = 1'b1;
              end else begin
                if (!lo[ch[5:0]]) cnt = cnt + 3'd1;
                lo[ch[5:0]] = 1'b1;
              end
            end
          end
          j.lo = lo; j.hi = hi; j.cnt = cnt;
          if (game_mode_i) begin
            arrows_d = '0;
          end else begin
            for (int i = 0; i < KeySlots; i++) begin
              case (usages_i[i*8 +: 8])
                8'h52: arr[0] = 1'b1;
                8'h51: arr[1] = 1'b1;
                8'h50: arr[2] = 1'b1;
                8'h4F: arr[3] = 1'b1;
                8'h60: if (!num_t) arr[0] = 1'b1;
                8'h5A: if (!num_t) arr[1] = 1'b1;
                8'h5C: if (!num_t) arr[2] = 1'b1;
                8'h5E: if (!num_t) arr[3] = 1'b1;
                default: ;
              endcase
            end
            newly = arr & ~arrows_q;
            if (newly != 4'd0) begin
              press_d = '0; rep_d = '0;
            end
            j.nav = newly;
            arrows_d = arr;
          end
          prev_mods_d = modifiers_i;
          prev_d = usages_i;
        end
      end
      CMD_RELEASE: begin
        emit = 1'b1;
        arrows_d = '0; prev_mods_d = '0; prev_d = '0;
      end
      CMD_TICK: begin
        if (pa != 16'hFFFF) pa = pa + 16'd1;
        if (ra != 16'hFFFF) ra = ra + 16'd1;
        if (arrows_q != 4'd0 && !game_mode_i && pa >= delay_i && ra >= interval_i) begin
          ra = '0;
          j.nav = arrows_q;
        end
        press_d = pa; rep_d = ra;
        j.led_send = led_due_q;
        j.led = {caps_q, num_q};
        led_due_d = 1'b0;
        emit = (j.nav != 4'd0) || led_due_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_q      <= '0;
      caps_q      <= 1'b0;
      num_q       <= 1'b1;
      led_due_q   <= 1'b1;
      arrows_q    <= '0;
      press_q     <= '0;
      rep_q       <= '0;
      job_valid_o <= 1'b0;
    end else if (job_ready_i) begin
      job_valid_o <= acc && emit;
      if (acc) begin
        prev_mods_q <= prev_mods_d;
        prev_q      <= prev_d;
        caps_q      <= caps_d;
        num_q       <= num_d;
        led_due_q   <= led_due_d;
        arrows_q    <= arrows_d;
        press_q     <= press_d;
        rep_q       <= rep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_i && acc) job_o <= j;
  end

endmodule

// ----- rtl/core/hbkd_back.sv -----
// back: steps a job through its result sequence, one result per cycle while the output is not stalled
module hbkd_back import hbkd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_ready_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  localparam logic [4:0] StepHeld = 5'd0;
  localparam logic [4:0] StepLast = 5'd17;

  logic       busy_q;
  job_t       job_q;
  logic [4:0] step_q;
  logic       ovalid_q;
  res_t       ores_q;
  logic       fire, load, has, more;
  logic [4:0] cur, nxt;
  logic [2:0] idx;
  logic [1:0] mi;
  logic [7:0] u, c;
  res_t       r;

  function automatic logic hit(input logic [47:0] s, input logic [7:0] v);
    logic f;
    f = 1'b0;
    for (int k = 0; k < KeySlots; k++) if (s[k*8 +: 8] == v) f = 1'b1;
    return f;
  endfunction

  // step encodes: 0 first result, 1..6 releases, 7..12 presses, 13..16 modifiers, 17 trailing nav result
  function automatic logic present(input job_t j, input logic [4:0] s);
    logic       p;
    logic [7:0] v;
    logic [1:0] m;
    logic [2:0] x;
    p = 1'b0; v = '0; m = '0; x = '0;
    if (s == StepHeld) p = 1'b1;
    else if (j.cmd == CMD_TICK) p = (s == 5'd1) && j.led_send && j.nav != 4'd0;
    else if (!j.game) p = 1'b0;
    else if (s <= 5'd6) begin
      x = 3'(s - 5'd1);
      v = j.prev[x*8 +: 8];
      if (j.cmd == CMD_RELEASE) p = game_code(v) != 8'h00;
      else p = v != 8'h00 && !hit(j.us, v) && game_code(v) != 8'h00;
    end else if (s <= 5'd12) begin
      x = 3'(s - 5'd7);
      v = j.us[x*8 +: 8];
      p = j.cmd == CMD_REPORT && v != 8'h00 && !hit(j.prev, v) && game_code(v) != 8'h00;
    end else if (s <= 5'd16) begin
      m = 2'(s - 5'd13);
      if (j.cmd == CMD_RELEASE) p = (j.prev_mods & mod_mask(m)) != 8'h00;
      else p = ((j.mods & mod_mask(m)) != 8'h00) != ((j.prev_mods & mod_mask(m)) != 8'h00);
    end
    return p;
  endfunction

  assign cur  = step_q;
  assign fire = busy_q && (!ovalid_q || res_ready_i);
  assign job_ready_o = !busy_q || (fire && r.last);
  assign load = job_valid_i && job_ready_o;

  always_comb begin
    nxt = StepLast;
    more = 1'b0;
    for (int s = 16; s >= 1; s--) begin
      if (5'(s) > cur && present(job_q, 5'(s))) begin
        nxt = 5'(s); more = 1'b1;
      end
    end
    has = 1'b1;
    idx = '0; mi = '0; u = '0; c = '0;
    r = '0;
    r.last = !more;
    if (job_q.cmd == CMD_TICK) begin
      if (cur == StepHeld && job_q.nav != 4'd0) begin
        r.kind = KIND_NAV; r.nav_dirs = job_q.nav;
      end else begin
        r.kind = KIND_LED; r.led_bits = job_q.led;
      end
    end else if (cur == StepHeld) begin
      r.kind = KIND_HELD;
      if (job_q.cmd == CMD_REPORT) begin
        r.held_low = job_q.lo; r.held_high = job_q.hi; r.held_count = job_q.cnt;
      end
      if (job_q.cmd == CMD_REPORT && !job_q.game && job_q.nav != 4'd0) r.last = 1'b0;
    end else if (cur == StepLast) begin
      r.kind = KIND_NAV; r.nav_dirs = job_q.nav; r.last = 1'b1;
    end else if (cur <= 5'd6) begin
      idx = 3'(cur - 5'd1);
      u = job_q.prev[idx*8 +: 8];
      r.kind = KIND_EDGE; r.key_code = game_code(u);
    end else if (cur <= 5'd12) begin
      idx = 3'(cur - 5'd7);
      u = job_q.us[idx*8 +: 8];
      r.kind = KIND_EDGE; r.key_code = game_code(u); r.pressed = 1'b1;
    end else begin
      mi = 2'(cur - 5'd13);
      c = mod_code(mi);
      r.kind = KIND_EDGE; r.key_code = c;
      r.pressed = job_q.cmd == CMD_REPORT && (job_q.mods & mod_mask(mi)) != 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= StepHeld;
      ovalid_q <= 1'b0;
    end else begin
      if (res_ready_i && ovalid_q && !fire) ovalid_q <= 1'b0;
      if (fire) begin
        ovalid_q <= has;
        if (r.last) begin
          busy_q <= 1'b0;
        end else if (!more) begin
          step_q <= StepLast;
        end else begin
          step_q <= nxt;
        end
      end
      if (load) begin
        busy_q <= 1'b1;
        step_q <= StepHeld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    if (fire) ores_q <= r;
  end

  assign res_valid_o = ovalid_q;
  assign res_o       = ores_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> res_valid_o)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> busy_q)
    else $error("job not taken");

endmodule
